[src/dclr_pkg.sv]
// shared types and character constants for the decimal command line receiver
package dclr_pkg;

    // input transfer payload
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } cmd_t;

    // result transfer payload
    typedef struct packed {
        logic [7:0] value;
        logic       accepted;
    } result_t;

    // action codes
    localparam logic ACTION_BYTE      = 1'b0;
    localparam logic ACTION_LINE_ERR  = 1'b1;

    // character codes
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_DEL   = 8'd127;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // prefix saturation value and register reset value
    localparam logic [7:0] SAT_VALUE       = 8'd255;
    localparam logic [7:0] MAX_VALUE_RESET = 8'd100;

    // operation codes carried into the update stage
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_DIGIT = 2'd1;
    localparam logic [1:0] OP_TERM  = 2'd2;

endpackage

[src/dclr_stack_mem.sv]
// prefix value stack memory, one write port and one registered read port
module dclr_stack_mem
    import dclr_pkg::*;
#(
    parameter int DEPTH = 15,
    parameter int AW    = 4
)(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] prefix_mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prefix_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= prefix_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/dclr_result_queue.sv]
// two entry result queue between the update stage and the result channel
module dclr_result_queue
    import dclr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    input  logic        pop,
    output logic        head_valid,
    output result_t     head_data,
    output logic [1:0]  level
);

    logic [1:0] level_reg, level_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;

    // occupancy and slot movement
    always_comb
    begin
        level_next = level_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (level_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = push_data;
                    level_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    slot0_next = push_data;
                end
                else if (pop)
                begin
                    level_next = 2'd0;
                end
                else if (push)
                begin
                    slot1_next = push_data;
                    level_next = 2'd2;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    if (push)
                    begin
                        slot1_next = push_data;
                    end
                    else
                    begin
                        level_next = 2'd1;
                    end
                end
            end
            default:
            begin
                level_next = 2'd0;
            end
        endcase
    end

    // occupancy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 2'd0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign head_valid = (level_reg != 2'd0);
    assign head_data  = slot0_reg;
    assign level      = level_reg;

endmodule

[src/decimal_command_line_receiver_unit.sv]
// top level of the decimal command line receiver
//
//  channel   direction  handshake                     payload
//  cmd       in         cmd_valid / cmd_ready         cmd (action, rx_byte)
//  result    out        result_valid / result_ready   result (value, accepted)
//  max_value in         max_value_we, no wait         max_value_data
//
//  one command transfer per cycle while cmd_ready is high, in stages: decode and stack read,
//  then prefix update and write back through the stack memory's single ports
//  a CR or LF result passes the update stage and the result queue registers before the result port
//  a command accepted back to back after a digit takes the new prefix from a forwarding path
//  reset clears the line and the result queue and sets max_value to 100
//  cmd_ready drops while the result queue, counting the update stage, holds two
module decimal_command_line_receiver_unit
    import dclr_pkg::*;
#(
    parameter int LINE_DEPTH = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        max_value_we,
    input  logic [7:0]  max_value_data
);

    localparam int STACK_DEPTH = LINE_DEPTH - 1;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] STACK_FULL = CW'(STACK_DEPTH);

    logic [7:0]    max_value_reg;
    logic [CW-1:0] count_reg, count_next;

    // update stage registers
    logic          b_valid_reg;
    logic [1:0]    b_op_reg, b_op_next;
    logic [3:0]    b_digit_reg;
    logic [AW-1:0] b_waddr_reg;
    logic          b_empty_reg;
    logic          b_fwd_reg;
    logic [7:0]    fwd_value_reg;

    logic          accept;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [7:0]    top_value;
    logic [11:0]   product;
    logic [7:0]    new_prefix;
    logic          mem_we;
    logic          b_push;
    logic          value_ok;
    result_t       b_result;
    logic          pop;
    logic [1:0]    q_level;
    logic [2:0]    occ_next;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= MAX_VALUE_RESET;
        end
        else if (max_value_we)
        begin
            max_value_reg <= max_value_data;
        end
    end

    // input transfer and room left in the result queue
    assign pop      = result_valid && result_ready;
    assign b_push   = b_valid_reg && (b_op_reg == OP_TERM);
    assign occ_next = 3'(q_level) + 3'(b_push) - 3'(pop);
    assign cmd_ready = (occ_next < 3'd2);
    assign accept    = cmd_valid && cmd_ready;

    // read the current top of the stack
    assign rd_addr = AW'(count_reg - CW'(1));

    // decode stage: line length and operation
    always_comb
    begin
        count_next = count_reg;
        b_op_next  = OP_NONE;
        if (cmd.action == ACTION_LINE_ERR)
        begin
            count_next = '0;
        end
        else
        begin
            case (cmd.rx_byte) inside
                CHAR_CR, CHAR_LF:
                begin
                    if (count_reg != '0)
                    begin
                        b_op_next  = OP_TERM;
                        count_next = '0;
                    end
                end
                CHAR_BS, CHAR_DEL:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                [CHAR_ZERO:CHAR_NINE]:
                begin
                    if (count_reg < STACK_FULL)
                    begin
                        b_op_next  = OP_DIGIT;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = '0;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // line length and update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            b_valid_reg <= 1'b0;
            b_op_reg    <= OP_NONE;
        end
        else
        begin
            b_valid_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
                b_op_reg  <= b_op_next;
            end
        end
    end

    // update stage payload; forward when the previous item wrote the entry read now
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_digit_reg <= 4'(cmd.rx_byte - CHAR_ZERO);
            b_waddr_reg <= count_reg[AW-1:0];
            b_empty_reg <= (count_reg == '0);
            b_fwd_reg   <= b_valid_reg && (b_op_reg == OP_DIGIT);
        end
        fwd_value_reg <= new_prefix;
    end

    // prefix stack memory
    dclr_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (b_waddr_reg),
        .wr_data (new_prefix),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // new prefix: top times ten plus digit, saturated
    always_comb
    begin
        if (b_empty_reg)
        begin
            top_value = 8'd0;
        end
        else if (b_fwd_reg)
        begin
            top_value = fwd_value_reg;
        end
        else
        begin
            top_value = rd_data;
        end
        product = {1'b0, top_value, 3'b000} + {3'b000, top_value, 1'b0}
                  + {8'd0, b_digit_reg};
        new_prefix = (product > 12'(SAT_VALUE)) ? SAT_VALUE : product[7:0];
    end

    assign mem_we = b_valid_reg && (b_op_reg == OP_DIGIT);

    // result of a terminated line
    assign value_ok          = (top_value != SAT_VALUE) && (top_value <= max_value_reg);
    assign b_result.value    = value_ok ? top_value : 8'd0;
    assign b_result.accepted = value_ok;

    dclr_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (b_push),
        .push_data  (b_result),
        .pop        (pop),
        .head_valid (result_valid),
        .head_data  (result),
        .level      (q_level)
    );

    // line length stays within the stack
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= STACK_FULL)
        else $error("line length beyond stack depth");

    // a rejected result carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.accepted |-> result.value == 8'd0)
        else $error("rejected result with non-zero value");

    // an accepted result is never the saturation value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.accepted |-> result.value != SAT_VALUE)
        else $error("saturated prefix accepted");

    // the queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        q_level == 2'd2 && !pop |-> !b_push)
        else $error("result queue overflow");

endmodule

[bench/decimal_command_line_receiver_unit_test.sv]
// testbench for the decimal command line receiver unit
`timescale 1ns / 100ps

module decimal_command_line_receiver_unit_test;
    import dclr_pkg::*;

    localparam int LINE_DEPTH    = 16;
    localparam int STACK_DEPTH   = LINE_DEPTH - 1;
    localparam int ITEM_TARGET   = 1950;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    cmd_t       cmd;
    logic       result_valid;
    logic       result_ready;
    result_t    result;
    logic       max_value_we;
    logic [7:0] max_value_data;

    // line editor model: register copy, prefix stack and digit count
    logic [7:0]  model_max;
    logic [7:0]  model_prefix [STACK_DEPTH];
    int unsigned model_digits;
    result_t     expected_results [$];

    int error_count = 0;
    int items_sent  = 0;
    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    bit hold_request  = 1'b0;

    decimal_command_line_receiver_unit #(
        .LINE_DEPTH (LINE_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .max_value_we   (max_value_we),
        .max_value_data (max_value_data)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // apply one accepted transfer to the line model
    function automatic void edit_line(cmd_t c);
        logic [7:0]  top;
        int unsigned next;
        result_t     r;
        if (c.action == ACTION_LINE_ERR)
        begin
            model_digits = 0;
        end
        else if (c.rx_byte == CHAR_CR || c.rx_byte == CHAR_LF)
        begin
            // terminator on an empty line gives nothing
            if (model_digits != 0)
            begin
                top        = model_prefix[model_digits - 1];
                r.value    = '0;
                r.accepted = 1'b0;
                // saturated prefix is never accepted
                if (top != SAT_VALUE && top <= model_max)
                begin
                    r.value    = top;
                    r.accepted = 1'b1;
                end
                expected_results.push_back(r);
                model_digits = 0;
            end
        end
        else if (c.rx_byte == CHAR_BS || c.rx_byte == CHAR_DEL)
        begin
            if (model_digits != 0)
                model_digits--;
        end
        else if (c.rx_byte >= CHAR_ZERO && c.rx_byte <= CHAR_NINE)
        begin
            // a digit on a full line clears it instead
            if (model_digits < STACK_DEPTH)
            begin
                next = c.rx_byte - CHAR_ZERO;
                if (model_digits != 0)
                    next += 10 * model_prefix[model_digits - 1];
                if (next > SAT_VALUE)
                    next = SAT_VALUE;
                model_prefix[model_digits] = next[7:0];
                model_digits++;
            end
            else
            begin
                model_digits = 0;
            end
        end
    endfunction

    // check result transfers, then update the model from command and register ports
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n !== 1'b1)
        begin
            model_max    = MAX_VALUE_RESET;
            model_digits = 0;
            expected_results.delete();
        end
        else
        begin
            if (result_valid === 1'b1 && result_ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, value %0d accepted %0b",
                             $time, result.value, result.accepted);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.value !== want.value)
                    begin
                        $display("%0t: value mismatch, expected %0d actual %0d",
                                 $time, want.value, result.value);
                        error_count++;
                    end
                    if (result.accepted !== want.accepted)
                    begin
                        $display("%0t: accepted mismatch, expected %0b actual %0b",
                                 $time, want.accepted, result.accepted);
                        error_count++;
                    end
                end
            end
            if (cmd_valid === 1'b1 && cmd_ready === 1'b1)
                edit_line(cmd);
            if (max_value_we === 1'b1)
                model_max = max_value_data;
        end
    end

    // result receiver: random back-pressure plus an occasional long hold-off
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            result_ready <= !(receiver_gaps && $urandom_range(99) < 12);
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // offer one command and wait for its transfer
    task automatic send_cmd(cmd_t c);
        int gap;
        // occasional random gaps, so idle time stays near one in eight
        if (sender_gaps && $urandom_range(99) < 5)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            cmd_valid <= 1'b0;
            cmd       <= cmd_t'(9'($urandom));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (cmd_ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_char(logic [7:0] b);
        send_cmd(cmd_t'({ACTION_BYTE, b}));
    endtask

    task automatic send_digits(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_line(string s, logic [7:0] term);
        send_digits(s);
        send_char(term);
    endtask

    function automatic logic [7:0] random_digit();
        return 8'(CHAR_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] random_term();
        return $urandom_range(1) ? CHAR_CR : CHAR_LF;
    endfunction

    // stop offering and wait until every expected result has arrived
    task automatic drain_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        // digits may still be in the pipeline without a result
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_max_value(logic [7:0] v);
        drain_results();
        @(negedge clk);
        max_value_we   <= 1'b1;
        max_value_data <= v;
        @(negedge clk);
        max_value_we   <= 1'b0;
    endtask

    // one random line: mostly well formed, some broken, some noise
    task automatic send_random_line();
        int kind;
        int len;
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            len = ($urandom_range(99) < 85) ? $urandom_range(1, 3)
                                            : $urandom_range(1, STACK_DEPTH);
            repeat (len)
            begin
                send_char(random_digit());
                if ($urandom_range(99) < 6)
                    send_char($urandom_range(1) ? CHAR_BS : CHAR_DEL);
            end
            send_char(random_term());
        end
        else if (kind < 88)
        begin
            // aborted by a status error, overrun past the line, or empty
            len = $urandom_range(0, LINE_DEPTH + 1);
            repeat (len) send_char(random_digit());
            if ($urandom_range(1))
                send_cmd(cmd_t'({ACTION_LINE_ERR, 8'($urandom)}));
            else
                send_char(random_term());
        end
        else
        begin
            repeat ($urandom_range(1, 3)) send_cmd(cmd_t'(9'($urandom)));
        end
    endtask

    // field extremes, editing keys and status error at the reset maximum
    task automatic test_directed();
        send_line("0", CHAR_CR);
        send_line("100", CHAR_LF);
        send_line("101", CHAR_CR);
        // empty terminator and backspace on an empty line
        send_char(CHAR_CR);
        send_char(CHAR_BS);
        send_digits("12");
        send_char(CHAR_DEL);
        send_line("3", CHAR_CR);
        // non-digit bytes are ignored
        send_char(8'h00);
        send_char(8'hFF);
        // status error clears the line and ignores its byte
        send_digits("5");
        send_cmd(cmd_t'({ACTION_LINE_ERR, CHAR_NINE}));
        send_line("7", CHAR_CR);
    endtask

    // lines at and past the line depth
    task automatic test_full_line();
        send_line("000000000000001", CHAR_CR);
        send_digits("9999999999999999");
        send_char(CHAR_LF);
        send_digits("000000000000000");
        send_char(CHAR_BS);
        send_line("4", CHAR_CR);
    endtask

    // smallest and largest register settings, prefix saturation
    task automatic test_max_extremes();
        program_max_value(8'd0);
        send_line("0", CHAR_CR);
        send_line("00", CHAR_LF);
        send_line("1", CHAR_CR);
        program_max_value(8'd255);
        send_line("254", CHAR_CR);
        send_line("255", CHAR_LF);
        send_line("999", CHAR_CR);
        send_line("2550", CHAR_LF);
        program_max_value(8'd254);
        send_line("254", CHAR_CR);
        send_line("0099", CHAR_LF);
    endtask

    task automatic test_random_lines(int upto);
        while (items_sent < upto)
            send_random_line();
    endtask

    // a long stretch at full rate on both sides
    task automatic test_no_idle(int upto);
        drain_results();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        test_random_lines(upto);
        drain_results();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // receiver holds off while short lines keep coming, so the input stalls
    task automatic test_result_hold_off();
        hold_request = 1'b1;
        repeat (30)
        begin
            send_char(random_digit());
            send_char(random_term());
        end
        drain_results();
    endtask

    // sender waits for every result after each line
    task automatic test_sender_pause();
        repeat (15)
        begin
            send_random_line();
            drain_results();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        max_value_we   = 1'b0;
        max_value_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_line();
        test_max_extremes();
        program_max_value(8'($urandom_range(255)));
        test_random_lines(700);
        program_max_value(8'd254);
        test_no_idle(1100);
        test_result_hold_off();
        program_max_value(8'd9);
        test_sender_pause();
        program_max_value(8'($urandom_range(255)));
        test_random_lines(ITEM_TARGET);

        drain_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
